// ===== rtl/core/pcx_pkg.sv =====
// Shared types, constants and register map of the PCX run-length line decoder.
`default_nettype none

package pcx_pkg;

	// Default depth of the command queue between front and back.
	localparam int unsigned CMDQ_DEPTH_DEF = 4;

	// A byte with both top bits set is a repeat count.
	localparam logic [7:0] COUNT_MARK = 8'hc0;
	localparam logic [5:0] COUNT_MASK = 6'h3f;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_BYTES_PER_LINE = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd2;

	// Register reset values.
	localparam logic [15:0] BYTES_PER_LINE_RST = 16'd320;
	localparam logic [15:0] IMAGE_WIDTH_RST    = 16'd320;
	localparam logic [15:0] IMAGE_HEIGHT_RST   = 16'd200;

	// One decoded command: a pixel value repeated a number of times, or a count
	// byte that only checks whether the image is already done.
	typedef struct packed {
		logic       count_only;
		logic [5:0] reps;
		logic [7:0] value;
	} cmd_t;

	// Image geometry as held in the configuration registers.
	typedef struct packed {
		logic [15:0] bytes_per_line;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} cfg_t;

	// Back end sequencer states.
	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/pcx_if.sv =====
// Valid/ready channel interfaces for encoded bytes and decoded pixels.
`default_nettype none

interface pcx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

interface pcx_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pixel;
	logic [15:0] column;
	logic [15:0] row;
	logic        last_of_input;
	logic        frame_end;

	modport source (output valid, output pixel, output column, output row,
		output last_of_input, output frame_end, input ready);
	modport sink (input valid, input pixel, input column, input row,
		input last_of_input, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pcx_rle_line_decoder.sv =====
// Top level of the PCX run-length line decoder with its configuration registers.
//
//   Channel  Direction  Handshake       Carries
//   code     in         valid/ready     code_byte
//   pixels   out        valid/ready     pixel, column, row, last_of_input, frame_end
//   APB      in         psel/penable    bytes_per_line, image_width, image_height
//
// A literal byte and a data byte with its repeat count each become one command that
// the back end expands, and a count byte passes through the front end and the back
// end, where it only checks for the end of the image. The pixel sequencer in the
// back end, one pixel per cycle within a run unless the output stalls, sets the rate.
// The command queue lets the front end keep taking bytes while a run expands.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
// A stalled pixel output holds the sequencer; bytes then wait once the queue fills.
`default_nettype none

module pcx_rle_line_decoder #(
	parameter int unsigned CMDQ_DEPTH = pcx_pkg::CMDQ_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pcx_in_if.sink           code,
	pcx_out_if.source        pixels,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import pcx_pkg::*;

	cfg_t cfg_q;
	logic cfg_wr;
	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	cmd_t pop_cmd;
	logic not_empty;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bytes_per_line <= BYTES_PER_LINE_RST;
			cfg_q.image_width    <= IMAGE_WIDTH_RST;
			cfg_q.image_height   <= IMAGE_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BYTES_PER_LINE: cfg_q.bytes_per_line <= pwdata[15:0];
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= pwdata[15:0];
				REG_IMAGE_HEIGHT:   cfg_q.image_height   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_BYTES_PER_LINE: prdata = {16'd0, cfg_q.bytes_per_line};
			REG_IMAGE_WIDTH:    prdata = {16'd0, cfg_q.image_width};
			REG_IMAGE_HEIGHT:   prdata = {16'd0, cfg_q.image_height};
			default:            prdata = '0;
		endcase
	end

	pcx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.code     (code),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	pcx_cmdq #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.not_empty (not_empty)
	);

	pcx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (not_empty),
		.cmd       (pop_cmd),
		.pop       (pop),
		.pixels    (pixels)
	);

endmodule

`default_nettype wire

// ===== rtl/core/pcx_front.sv =====
// Front end: accepts encoded bytes and turns them into repeat commands.
`default_nettype none

module pcx_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	pcx_in_if.sink            code,
	input  wire logic         full,
	output logic              push,
	output pcx_pkg::cmd_t     push_cmd
);
	import pcx_pkg::*;

	logic       await_q;
	logic [5:0] run_q;
	logic       accept;
	logic       is_count;

	// Bytes are taken whenever the queue has room.
	assign code.ready = !full;
	assign accept     = code.valid && code.ready;
	assign is_count   = (code.code_byte & COUNT_MARK) == COUNT_MARK;

	// Every byte becomes a command; a count byte only carries the image-done check.
	assign push                = accept;
	assign push_cmd.count_only = !await_q && is_count;
	assign push_cmd.reps       = await_q ? run_q : 6'd1;
	assign push_cmd.value      = code.code_byte;

	// Remember a pending count until its data byte arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q <= 1'b0;
			run_q   <= '0;
		end else if (accept) begin
			if (await_q) begin
				await_q <= 1'b0;
			end else if (is_count) begin
				await_q <= 1'b1;
				run_q   <= code.code_byte[5:0] & COUNT_MASK;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pcx_cmdq.sv =====
// Short command queue that decouples the front end from the back end.
`default_nettype none

module pcx_cmdq #(
	parameter int unsigned DEPTH = pcx_pkg::CMDQ_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  pcx_pkg::cmd_t       push_cmd,
	output logic                full,
	input  wire logic           pop,
	output pcx_pkg::cmd_t       pop_cmd,
	output logic                not_empty
);
	import pcx_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pcx_back.sv =====
// Back end: expands commands into pixels and tracks columns, lines and frame end.
`default_nettype none

module pcx_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  pcx_pkg::cfg_t     cfg,
	input  wire logic         cmd_valid,
	input  pcx_pkg::cmd_t     cmd,
	output logic              pop,
	pcx_out_if.source         pixels
);
	import pcx_pkg::*;

	bk_state_t   state_q;
	bk_state_t   state_d;
	logic [5:0]  reps_left_q;
	logic [7:0]  value_q;
	logic [16:0] end_col_q;
	logic        last_line_q;
	logic [16:0] col_q;
	logic [15:0] line_q;
	logic        done_q;

	logic        ovalid_q;
	logic [7:0]  opix_q;
	logic [15:0] ocol_q;
	logic [15:0] orow_q;
	logic        olast_q;
	logic        oend_q;

	logic        slot_free;
	logic        halt;
	logic        line_end;
	logic        step;
	logic        finish;
	logic        show;
	logic        last_pix;
	logic [15:0] line_next;
	logic [16:0] col_inc;

	// Status of the current command and line.
	assign slot_free = !ovalid_q || pixels.ready;
	assign halt      = done_q || (line_q >= cfg.image_height);
	assign line_end  = (cfg.bytes_per_line == '0) ? (end_col_q != '0)
		: (end_col_q >= {1'b0, cfg.bytes_per_line});
	assign step      = (state_q == BK_RUN) && ((reps_left_q == '0) || slot_free);
	assign finish    = step && (reps_left_q <= 6'd1);
	assign col_inc   = col_q + 17'd1;
	assign show      = step && (reps_left_q != '0) && (col_q < {1'b0, cfg.image_width});
	assign last_pix  = (reps_left_q == 6'd1) || (col_inc >= {1'b0, cfg.image_width});
	assign line_next = line_q + 16'd1;

	// Next state and queue pop; a count byte only checks for the end of the image.
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					pop = 1'b1;
					if (!halt && !cmd.count_only) begin
						state_d = BK_RUN;
					end
				end
			end
			BK_RUN: begin
				if (finish) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command setup, column and line counting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reps_left_q <= '0;
			col_q       <= '0;
			line_q      <= '0;
			done_q      <= 1'b0;
			last_line_q <= 1'b0;
			end_col_q   <= '0;
		end else begin
			if (state_q == BK_IDLE && pop) begin
				if (halt) begin
					done_q <= 1'b1;
				end else if (!cmd.count_only) begin
					reps_left_q <= cmd.reps;
					end_col_q   <= col_q + 17'(cmd.reps);
					last_line_q <= line_next >= cfg.image_height;
				end
			end
			if (step) begin
				if (reps_left_q != '0) begin
					col_q       <= col_inc;
					reps_left_q <= reps_left_q - 6'd1;
				end
				if (finish && line_end) begin
					col_q  <= '0;
					line_q <= line_next;
					if (last_line_q) begin
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// Pixel value of the current command.
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && pop) begin
			value_q <= cmd.value;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (show) begin
			ovalid_q <= 1'b1;
		end else if (pixels.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (show) begin
			opix_q  <= value_q;
			ocol_q  <= col_q[15:0];
			orow_q  <= line_q;
			olast_q <= last_pix;
			oend_q  <= last_pix && line_end && last_line_q;
		end
	end

	assign pixels.valid         = ovalid_q;
	assign pixels.pixel         = opix_q;
	assign pixels.column        = ocol_q;
	assign pixels.row           = orow_q;
	assign pixels.last_of_input = olast_q;
	assign pixels.frame_end     = oend_q;

endmodule

`default_nettype wire

// ===== rtl/core/pcx_checker.sv =====
// Port-level checks on the decoder's pixel output, bound to the top level.
`default_nettype none

module pcx_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  pixel,
	input wire logic [15:0] column,
	input wire logic [15:0] row,
	input wire logic        last_of_input,
	input wire logic        frame_end
);

	logic        out_acc;
	logic        seen_end_q;
	logic        open_q;
	logic [15:0] prev_col_q;
	logic [15:0] prev_row_q;

	assign out_acc = out_valid && out_ready;

	// Track the end of the frame and the previous pixel of an unfinished item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_end_q <= 1'b0;
			open_q     <= 1'b0;
			prev_col_q <= '0;
			prev_row_q <= '0;
		end else if (out_acc) begin
			seen_end_q <= seen_end_q || frame_end;
			open_q     <= !last_of_input;
			prev_col_q <= column;
			prev_row_q <= row;
		end
	end

	// A stalled pixel stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(column)
			&& $stable(row) && $stable(last_of_input) && $stable(frame_end))
		else $error("pixel output changed while stalled");

	// The end of the frame is always the last pixel of its item.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> last_of_input)
		else $error("frame end without last of input");

	// Nothing follows the end of the frame.
	a_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		seen_end_q |-> !out_valid)
		else $error("pixel after frame end");

	// Pixels of one item sit at consecutive columns of one line.
	a_run_cols: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && open_q |-> (column == prev_col_q + 16'd1) && (row == prev_row_q))
		else $error("run pixels not contiguous");

endmodule

bind pcx_rle_line_decoder pcx_checker u_pcx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (pixels.valid),
	.out_ready     (pixels.ready),
	.pixel         (pixels.pixel),
	.column        (pixels.column),
	.row           (pixels.row),
	.last_of_input (pixels.last_of_input),
	.frame_end     (pixels.frame_end)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the PCX run-length line decoder.
module tb;
	import pcx_pkg::*;

	// One decoded pixel as it leaves the block.
	typedef struct packed {
		logic [7:0]  pixel;
		logic [15:0] column;
		logic [15:0] row;
		logic        last_of_input;
		logic        frame_end;
	} pixel_t;

	// An address past the register list; writes there must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	// Cycles for the command queue and a long run to drain when no pixel is due.
	localparam int SETTLE = 400;
	localparam int LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;

	pcx_in_if code_ch();
	pcx_out_if pix_ch();

	pcx_rle_line_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.code(code_ch),
		.pixels(pix_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Encoded bytes waiting to be sent and pixels still due from the block.
	logic [7:0] byte_q[$];
	pixel_t pixel_q[$];

	// Decoder state as the block should hold it.
	cfg_t geom = '{BYTES_PER_LINE_RST, IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST};
	logic await_data = 1'b0;
	logic [5:0] run_len = '0;
	logic [16:0] col_cnt = '0;
	logic [15:0] line_cnt = '0;
	logic img_done = 1'b0;

	int idle_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	int cycles = 0;
	pixel_t want, got;

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Expand one encoded byte into the pixels it should produce.
	task automatic decode_byte(input logic [7:0] b);
		logic [6:0] reps;
		logic [16:0] line_len;
		logic have;
		pixel_t p;
		if (img_done || line_cnt >= geom.image_height) begin
			img_done = 1'b1;
			return;
		end
		if (await_data) begin
			await_data = 1'b0;
			reps = {1'b0, run_len};
		end else if ((b & COUNT_MARK) == COUNT_MARK) begin
			await_data = 1'b1;
			run_len = b[5:0] & COUNT_MASK;
			return;
		end else begin
			reps = 7'd1;
		end
		have = 1'b0;
		p = '0;
		for (int i = 0; i < reps; i++) begin
			if (col_cnt < {1'b0, geom.image_width}) begin
				if (have) begin
					pixel_q.push_back(p);
				end
				p = '{b, col_cnt[15:0], line_cnt, 1'b0, 1'b0};
				have = 1'b1;
			end
			col_cnt = col_cnt + 17'd1;
		end
		// A line closes after the code that reaches its length; overshoot is lost.
		line_len = (geom.bytes_per_line == 16'd0) ? 17'd1 : {1'b0, geom.bytes_per_line};
		if (col_cnt >= line_len) begin
			col_cnt = '0;
			line_cnt = line_cnt + 16'd1;
			if (line_cnt >= geom.image_height) begin
				img_done = 1'b1;
				p.frame_end = 1'b1;
			end
		end
		if (have) begin
			p.last_of_input = 1'b1;
			pixel_q.push_back(p);
		end else begin
			p.frame_end = 1'b0;
		end
	endtask

	// Byte driver: holds each item until it is taken, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_ch.valid <= 1'b0;
			code_ch.code_byte <= '0;
		end else if (!code_ch.valid || code_ch.ready) begin
			if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				code_ch.valid <= 1'b1;
				code_ch.code_byte <= byte_q.pop_front();
			end else begin
				code_ch.valid <= 1'b0;
				code_ch.code_byte <= 8'($urandom);
			end
		end
	end

	// Pixel receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.ready <= 1'b0;
		end else begin
			pix_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Each accepted byte adds its pixels to the list of those due.
	always @(posedge clk) begin
		if (arst_n && code_ch.valid && code_ch.ready) begin
			decode_byte(code_ch.code_byte);
		end
	end

	// Each accepted pixel must match the oldest one due.
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			got = '{pix_ch.pixel, pix_ch.column, pix_ch.row, pix_ch.last_of_input,
				pix_ch.frame_end};
			if (pixel_q.size() == 0) begin
				note_failure($sformatf("unexpected pixel %0d at col %0d row %0d",
					got.pixel, got.column, got.row));
			end else begin
				want = pixel_q.pop_front();
				if (got !== want) begin
					note_failure($sformatf(
						"pixel mismatch: expected %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
						want.pixel, want.column, want.row, want.last_of_input, want.frame_end,
						got.pixel, got.column, got.row, got.last_of_input, got.frame_end));
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// One APB write: setup cycle, then access until pready, then a read-back.
	task automatic reg_write(input logic [1:0] idx, input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BYTES_PER_LINE: geom.bytes_per_line = value;
			REG_IMAGE_WIDTH: geom.image_width = value;
			REG_IMAGE_HEIGHT: geom.image_height = value;
			default: ;
		endcase
		@(negedge clk);
		if (prdata !== ((idx == REG_UNUSED) ? 32'd0 : {16'd0, value})) begin
			note_failure($sformatf("register %0d read back %0h after writing %0h",
				idx, prdata, value));
		end
	endtask

	// Wait until every byte is taken and every pixel due has arrived.
	task automatic wait_drained(input int settle);
		do @(negedge clk); while (byte_q.size() != 0 || code_ch.valid || pixel_q.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	// Let the block go idle, then change the line geometry, the idling and the stalling.
	task automatic start_phase(input logic [15:0] bpl, input logic [15:0] width,
			input int idle, input int stall);
		wait_drained(SETTLE);
		reg_write(REG_BYTES_PER_LINE, bpl);
		reg_write(REG_IMAGE_WIDTH, width);
		idle_pct = idle;
		stall_pct = stall;
		@(negedge clk);
	endtask

	// Mostly well-formed codes: literals and count/data pairs, with some noise.
	task automatic queue_random(input int n);
		int k;
		int pick;
		logic [5:0] reps;
		k = 0;
		while (k < n) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				byte_q.push_back(8'($urandom_range(191)));
				k++;
			end else if (pick < 92) begin
				reps = (pick < 85) ? 6'($urandom_range(8)) : 6'($urandom_range(63));
				byte_q.push_back(COUNT_MARK | {2'b00, reps});
				byte_q.push_back(8'($urandom));
				k += 2;
			end else begin
				byte_q.push_back(8'($urandom));
				k++;
			end
		end
	endtask

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset geometry: literals of every class, a short run and an empty run.
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hbf);
		byte_q.push_back(8'h7f);
		byte_q.push_back(8'h3f);
		byte_q.push_back(8'h80);
		byte_q.push_back(8'hc3);
		byte_q.push_back(8'hff);
		byte_q.push_back(8'hc0);
		byte_q.push_back(8'h55);

		// Narrow lines with padding: a full-length run, dropped columns and overshoot.
		start_phase(16'd5, 16'd3, 0, 0);
		reg_write(REG_IMAGE_HEIGHT, 16'hffff);
		reg_write(REG_UNUSED, 16'h0001);
		@(negedge clk);
		byte_q.push_back(8'hff);
		byte_q.push_back(8'hc0);
		for (int i = 1; i <= 5; i++) begin
			byte_q.push_back(8'(i));
		end
		byte_q.push_back(8'hc2);
		byte_q.push_back(8'h11);
		byte_q.push_back(8'hc4);
		byte_q.push_back(8'h22);

		// Zero line length acts as one; a run then spills past the line end.
		start_phase(16'd0, 16'hffff, 0, 0);
		byte_q.push_back(8'h10);
		byte_q.push_back(8'hc5);
		byte_q.push_back(8'h20);
		byte_q.push_back(8'h3e);

		// Random phases over several geometries and idling patterns.
		start_phase(16'd8, 16'd6, 0, 0);
		queue_random(20);
		start_phase(16'hffff, 16'hffff, 45, 0);
		queue_random(20);
		start_phase(16'd3, 16'd0, 0, 45);
		queue_random(20);
		start_phase(16'd40, 16'd40, 26, 26);
		queue_random(10);
		// Hold the sender back until the block has delivered everything.
		wait_drained(0);
		queue_random(10);
		start_phase(16'd1, 16'd2, 45, 45);
		queue_random(20);

		// Last two lines of the image, then bytes that must be ignored.
		start_phase(16'd4, 16'd4, 26, 26);
		reg_write(REG_IMAGE_HEIGHT, line_cnt + 16'd2);
		@(negedge clk);
		queue_random(20);
		wait_drained(SETTLE);
		reg_write(REG_IMAGE_HEIGHT, 16'd0);
		@(negedge clk);
		queue_random(6);

		wait_drained(SETTLE);
		if (pixel_q.size() != 0) begin
			note_failure($sformatf("%0d pixels never arrived", pixel_q.size()));
		end
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pcx_pkg.sv
rtl/core/pcx_if.sv
rtl/core/pcx_front.sv
rtl/core/pcx_cmdq.sv
rtl/core/pcx_back.sv
rtl/core/pcx_rle_line_decoder.sv
rtl/core/pcx_checker.sv
sim/tb.sv
